[rtl/core/billboard_basis_vectors_defines.svh]
// ----------------------------------------------------------------------------
// Billboard basis assertion macros
// Shared concurrent assertion forms for the billboard basis core.
// ----------------------------------------------------------------------------
`ifndef BILLBOARD_BASIS_VECTORS_DEFINES_SVH
`define BILLBOARD_BASIS_VECTORS_DEFINES_SVH

// same-cycle implication, off during reset
`define BBV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, also checked through reset
`define BBV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/bbv_pkg.sv]
// ----------------------------------------------------------------------------
// Billboard basis package
// Widths, vector types, codes and latencies of the billboard basis core.
// ----------------------------------------------------------------------------
package bbv_pkg;

  localparam int OUT_FRAC_BITS = 14;
  localparam int COMP_W        = 16;
  localparam int FIELD_W       = 32;
  localparam int IN_W          = FIELD_W + 1;
  localparam int MAG_W         = 30;
  localparam int SQ_W          = 2 * MAG_W;
  localparam int SUM_W         = SQ_W + 2;
  localparam int ROOT_W        = SUM_W / 2;
  localparam int REM_W         = ROOT_W + 4;
  localparam int NUM_W         = MAG_W + OUT_FRAC_BITS + 1;
  localparam int QUO_W         = OUT_FRAC_BITS + 1;
  localparam int PROD_W        = 2 * COMP_W;

  localparam int NORM_LAT      = 4 + ROOT_W + 1 + QUO_W + 1;
  localparam int XP_LAT        = 2;
  localparam int R2_DLY        = NORM_LAT + XP_LAT;
  localparam int R1_DLY        = 2 * R2_DLY;
  localparam int VLD_LEN       = 1 + 3 * NORM_LAT + 2 * XP_LAT;

  localparam int IN_FIELDS     = 12;
  localparam int OUT_FIELDS    = 9;
  localparam int IN_TDATA_W    = IN_FIELDS * FIELD_W;
  localparam int OUT_TDATA_W   = OUT_FIELDS * COMP_W;
  localparam int CFG_W         = 2;
  localparam int CFG_IDX_W     = 1;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [IN_W-1:0]   wide_t;
  typedef comp_t vec_t [3];
  typedef wide_t wvec_t [3];
  typedef logic [CFG_W-1:0] cfg_t;

  localparam cfg_t MODE_SCREEN = cfg_t'(0);
  localparam cfg_t MODE_CAMERA = cfg_t'(1);
  localparam cfg_t MODE_AXIS   = cfg_t'(2);
  localparam cfg_t AXIS_X      = cfg_t'(0);
  localparam cfg_t AXIS_Y      = cfg_t'(1);
  localparam cfg_t AXIS_Z      = cfg_t'(2);

  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LOCKED_AXIS = CFG_IDX_W'(1);

  localparam comp_t ONE     = comp_t'(1 << OUT_FRAC_BITS);
  localparam comp_t NEG_ONE = comp_t'(-(1 << OUT_FRAC_BITS));

endpackage

[rtl/core/billboard_basis_vectors.sv]
// Throughput: one word per cycle; every stage is pipelined, and a stalled
// output freezes the whole pipeline (in_tready = !out_tvalid || out_tready).
// Reset (rst_n low, synchronous) clears align_mode and locked_axis to 0 and
// empties the pipeline.
// ----------------------------------------------------------------------------
// Billboard basis vectors
// Right, up and forward unit vectors for screen, camera and axis aligned
// billboards: two normalizers, then two cross-and-normalize rounds.
// ----------------------------------------------------------------------------
`include "billboard_basis_vectors_defines.svh"

module billboard_basis_vectors (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // cam_up_x/y/z, cam_look_x/y/z, cam_pos_x/y/z, obj_pos_x/y/z (32b each)
  input  logic [bbv_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // right_x/y/z, up_x/y/z, fwd_x/y/z (16b each)
  output logic [bbv_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [bbv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bbv_pkg::CFG_W-1:0]           cfg_data
);
  import bbv_pkg::*;

  localparam vec_t EX = '{ONE, comp_t'(0), comp_t'(0)};
  localparam vec_t EY = '{comp_t'(0), ONE, comp_t'(0)};
  localparam vec_t EZ = '{comp_t'(0), comp_t'(0), ONE};

  cfg_t align_mode_r;
  cfg_t locked_axis_r;

  logic               en;
  logic [VLD_LEN-1:0] vld_r;
  logic               out_valid_r;

  wvec_t a1_r, a1_nxt;
  wvec_t b1_r, b1_nxt;
  vec_t  r1a, r1b, r2, r3;

  vec_t  r1a_d_r [R1_DLY];
  vec_t  r1b_d_r [R1_DLY];
  vec_t  r2_d_r  [R2_DLY];

  vec_t  xa [2];
  vec_t  xb [2];
  logic signed [PROD_W-1:0] prod_r [2][6];
  wvec_t diff_r [2];

  vec_t  o_rt, o_up, o_fw;
  vec_t  out_rt_r, out_up_r, out_fw_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_mode_r  <= MODE_SCREEN;
      locked_axis_r <= AXIS_X;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ALIGN_MODE:  align_mode_r  <= cfg_data;
        REG_LOCKED_AXIS: locked_axis_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input word unpack
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b1_nxt[i] = IN_W'($signed(in_tdata[i*FIELD_W +: FIELD_W]));
      if (align_mode_r == MODE_SCREEN) begin
        a1_nxt[i] = IN_W'($signed(in_tdata[(3+i)*FIELD_W +: FIELD_W]));
      end else begin
        a1_nxt[i] = IN_W'($signed(in_tdata[(6+i)*FIELD_W +: FIELD_W]))
                  - IN_W'($signed(in_tdata[(9+i)*FIELD_W +: FIELD_W]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[VLD_LEN-2:0], in_tvalid};
      out_valid_r <= vld_r[VLD_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= a1_nxt;
      b1_r <= b1_nxt;
    end
  end

  bbv_norm u_norm_1a (.clk(clk), .en(en), .vin(a1_r), .vout(r1a));
  bbv_norm u_norm_1b (.clk(clk), .en(en), .vin(b1_r), .vout(r1b));

  // cross operand select, second round
  always_comb begin
    vec_t nr1a;
    for (int i = 0; i < 3; i++) begin
      nr1a[i] = comp_t'(0) - r1a[i];
    end
    xa[0] = EX;
    xb[0] = EY;
    case (align_mode_r)
      MODE_SCREEN: begin
        xa[0] = r1b;
        xb[0] = nr1a;
      end
      MODE_CAMERA: begin
        xa[0] = r1b;
        xb[0] = r1a;
      end
      MODE_AXIS: begin
        case (locked_axis_r)
          AXIS_X: begin
            xa[0] = r1a;
            xb[0] = EX;
          end
          AXIS_Y: begin
            xa[0] = EY;
            xb[0] = r1a;
          end
          AXIS_Z: begin
            xa[0] = r1a;
            xb[0] = EZ;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // cross operand select, third round
  always_comb begin
    xa[1] = EX;
    xb[1] = EY;
    case (align_mode_r)
      MODE_CAMERA: begin
        xa[1] = r1a_d_r[R2_DLY-1];
        xb[1] = r2;
      end
      MODE_AXIS: begin
        case (locked_axis_r)
          AXIS_X: begin
            xa[1] = EX;
            xb[1] = r2;
          end
          AXIS_Y: begin
            xa[1] = r2;
            xb[1] = EY;
          end
          AXIS_Z: begin
            xa[1] = EZ;
            xb[1] = r2;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // cross product: products, then differences
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 2; r++) begin
        prod_r[r][0] <= xa[r][1] * xb[r][2];
        prod_r[r][1] <= xa[r][2] * xb[r][1];
        prod_r[r][2] <= xa[r][2] * xb[r][0];
        prod_r[r][3] <= xa[r][0] * xb[r][2];
        prod_r[r][4] <= xa[r][0] * xb[r][1];
        prod_r[r][5] <= xa[r][1] * xb[r][0];
        for (int i = 0; i < 3; i++) begin
          diff_r[r][i] <= IN_W'(prod_r[r][2*i]) - IN_W'(prod_r[r][2*i+1]);
        end
      end
    end
  end

  bbv_norm u_norm_2 (.clk(clk), .en(en), .vin(diff_r[0]), .vout(r2));
  bbv_norm u_norm_3 (.clk(clk), .en(en), .vin(diff_r[1]), .vout(r3));

  always_ff @(posedge clk) begin
    if (en) begin
      r1a_d_r[0] <= r1a;
      r1b_d_r[0] <= r1b;
      r2_d_r[0]  <= r2;
      for (int k = 1; k < R1_DLY; k++) begin
        r1a_d_r[k] <= r1a_d_r[k-1];
        r1b_d_r[k] <= r1b_d_r[k-1];
      end
      for (int k = 1; k < R2_DLY; k++) begin
        r2_d_r[k] <= r2_d_r[k-1];
      end
    end
  end

  // basis assembly
  always_comb begin
    vec_t f1;
    vec_t u1;
    vec_t s2;
    f1 = r1a_d_r[R1_DLY-1];
    u1 = r1b_d_r[R1_DLY-1];
    s2 = r2_d_r[R2_DLY-1];
    o_rt = EX;
    o_up = EY;
    o_fw = EZ;
    case (align_mode_r)
      MODE_SCREEN: begin
        o_rt = s2;
        o_up = u1;
        for (int i = 0; i < 3; i++) begin
          o_fw[i] = comp_t'(0) - f1[i];
        end
      end
      MODE_CAMERA: begin
        o_rt = s2;
        o_up = r3;
        o_fw = f1;
      end
      MODE_AXIS: begin
        case (locked_axis_r)
          AXIS_X: begin
            o_up = s2;
            o_fw = r3;
          end
          AXIS_Y: begin
            o_rt = s2;
            o_fw = r3;
          end
          AXIS_Z: begin
            o_rt = s2;
            o_up = r3;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rt_r <= o_rt;
      out_up_r <= o_up;
      out_fw_r <= o_fw;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_fw_r[2], out_fw_r[1], out_fw_r[0],
                       out_up_r[2], out_up_r[1], out_up_r[0],
                       out_rt_r[2], out_rt_r[1], out_rt_r[0]};

  `BBV_ASSERT_NEXT(a_rst_empty, !rst_n, !out_tvalid, "output word valid right after reset")
  `BBV_ASSERT_NEXT(a_stall_hold, rst_n && !in_tready, vld_r == $past(vld_r), "pipe moved in stall")
  `BBV_ASSERT_IMPL(a_unit_range, out_tvalid, out_rt_r[0] <= ONE && out_rt_r[0] >= NEG_ONE, "right_x out of unit range")

endmodule

[rtl/core/bbv_norm.sv]
// ----------------------------------------------------------------------------
// Billboard basis vector normalizer
// Pipelined fixed-point normalize: magnitude scaling, squared length,
// bit-per-stage square root and bit-per-stage rounded division.
// ----------------------------------------------------------------------------
module bbv_norm (
  input  logic           clk,
  input  logic           en,
  input  bbv_pkg::wvec_t vin,
  output bbv_pkg::vec_t  vout
);
  import bbv_pkg::*;

  logic [IN_W-1:0]   mag_a_r [3];
  logic [IN_W-1:0]   mag_a_nxt [3];
  logic [2:0]        neg_a_r;
  logic [MAG_W-1:0]  mag_b_r [3];
  logic [MAG_W-1:0]  mag_b_nxt [3];
  logic [2:0]        neg_b_r;
  logic              zero_b_r;
  logic              zero_b_nxt;
  logic [MAG_W-1:0]  mag_c_r [3];
  logic [SQ_W-1:0]   sq_c_r [3];
  logic [2:0]        neg_c_r;
  logic              zero_c_r;
  logic [MAG_W-1:0]  mag_d_r [3];
  logic [SUM_W-1:0]  sum_d_r;
  logic [2:0]        neg_d_r;
  logic              zero_d_r;

  logic [SUM_W-1:0]  rad_r [ROOT_W];
  logic [SUM_W-1:0]  rad_nxt [ROOT_W];
  logic [REM_W-1:0]  rem_r [ROOT_W];
  logic [REM_W-1:0]  rem_nxt [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];
  logic [MAG_W-1:0]  mag_s_r [ROOT_W][3];
  logic [2:0]        neg_s_r [ROOT_W];
  logic              zero_s_r [ROOT_W];

  logic [NUM_W-1:0]  num_e_r [3];
  logic [ROOT_W-1:0] len_e_r;
  logic [2:0]        neg_e_r;
  logic              zero_e_r;

  logic [NUM_W-1:0]  drem_r [QUO_W][3];
  logic [NUM_W-1:0]  drem_nxt [QUO_W][3];
  logic [QUO_W-1:0]  dq_r [QUO_W][3];
  logic [QUO_W-1:0]  dq_nxt [QUO_W][3];
  logic [ROOT_W-1:0] dlen_r [QUO_W];
  logic [2:0]        dneg_r [QUO_W];
  logic              dzero_r [QUO_W];

  vec_t vout_r;
  vec_t vout_nxt;

  // abs, scale below 2^30
  always_comb begin
    logic [IN_W-1:0] orv;
    logic [1:0]      sh;
    for (int i = 0; i < 3; i++) begin
      mag_a_nxt[i] = vin[i][IN_W-1] ? (~vin[i] + 1'b1) : vin[i];
    end
    orv = mag_a_r[0] | mag_a_r[1] | mag_a_r[2];
    if (orv[IN_W-1:MAG_W] == '0) begin
      sh = 2'd0;
    end else if (orv[IN_W-1:MAG_W+1] == '0) begin
      sh = 2'd1;
    end else if (orv[IN_W-1] == 1'b0) begin
      sh = 2'd2;
    end else begin
      sh = 2'd3;
    end
    for (int i = 0; i < 3; i++) begin
      mag_b_nxt[i] = MAG_W'(mag_a_r[i] >> sh);
    end
    zero_b_nxt = (orv == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg_a_r[i] <= vin[i][IN_W-1];
        mag_a_r[i] <= mag_a_nxt[i];
        mag_b_r[i] <= mag_b_nxt[i];
        mag_c_r[i] <= mag_b_r[i];
        sq_c_r[i]  <= SQ_W'(mag_b_r[i]) * SQ_W'(mag_b_r[i]);
        mag_d_r[i] <= mag_c_r[i];
      end
      neg_b_r  <= neg_a_r;
      zero_b_r <= zero_b_nxt;
      neg_c_r  <= neg_b_r;
      zero_c_r <= zero_b_r;
      sum_d_r  <= SUM_W'(sq_c_r[0]) + SUM_W'(sq_c_r[1]) + SUM_W'(sq_c_r[2]);
      neg_d_r  <= neg_c_r;
      zero_d_r <= zero_c_r;
    end
  end

  // square root, one result bit per stage
  always_comb begin
    logic [SUM_W-1:0]  s_rad;
    logic [REM_W-1:0]  s_rem;
    logic [REM_W-1:0]  r_in;
    logic [REM_W-1:0]  trial;
    logic [ROOT_W-1:0] s_root;
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        s_rad  = sum_d_r;
        s_rem  = '0;
        s_root = '0;
      end else begin
        s_rad  = rad_r[k-1];
        s_rem  = rem_r[k-1];
        s_root = root_r[k-1];
      end
      r_in       = {s_rem[REM_W-3:0], s_rad[SUM_W-1 -: 2]};
      trial      = {2'b00, s_root, 2'b01};
      rad_nxt[k] = s_rad << 2;
      if (r_in >= trial) begin
        rem_nxt[k]  = r_in - trial;
        root_nxt[k] = {s_root[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = r_in;
        root_nxt[k] = {s_root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      mag_s_r[0]  <= mag_d_r;
      neg_s_r[0]  <= neg_d_r;
      zero_s_r[0] <= zero_d_r;
      for (int k = 1; k < ROOT_W; k++) begin
        mag_s_r[k]  <= mag_s_r[k-1];
        neg_s_r[k]  <= neg_s_r[k-1];
        zero_s_r[k] <= zero_s_r[k-1];
      end
    end
  end

  // rounded quotient, one bit per stage
  always_comb begin
    logic [NUM_W-1:0]  dsh;
    logic [NUM_W-1:0]  s_rem;
    logic [QUO_W-1:0]  s_q;
    logic [ROOT_W-1:0] s_len;
    for (int j = 0; j < QUO_W; j++) begin
      s_len = (j == 0) ? len_e_r : dlen_r[j-1];
      dsh   = NUM_W'(s_len) << (QUO_W - 1 - j);
      for (int c = 0; c < 3; c++) begin
        if (j == 0) begin
          s_rem = num_e_r[c];
          s_q   = '0;
        end else begin
          s_rem = drem_r[j-1][c];
          s_q   = dq_r[j-1][c];
        end
        if (s_rem >= dsh) begin
          drem_nxt[j][c] = s_rem - dsh;
          dq_nxt[j][c]   = {s_q[QUO_W-2:0], 1'b1};
        end else begin
          drem_nxt[j][c] = s_rem;
          dq_nxt[j][c]   = {s_q[QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    comp_t qe;
    for (int c = 0; c < 3; c++) begin
      qe = comp_t'(dq_r[QUO_W-1][c]);
      if (dzero_r[QUO_W-1]) begin
        vout_nxt[c] = (c == 0) ? ONE : comp_t'(0);
      end else if (dneg_r[QUO_W-1][c]) begin
        vout_nxt[c] = comp_t'(0) - qe;
      end else begin
        vout_nxt[c] = qe;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        num_e_r[c] <= NUM_W'({mag_s_r[ROOT_W-1][c], {OUT_FRAC_BITS{1'b0}}})
                      + NUM_W'(root_r[ROOT_W-1] >> 1);
      end
      len_e_r  <= root_r[ROOT_W-1];
      neg_e_r  <= neg_s_r[ROOT_W-1];
      zero_e_r <= zero_s_r[ROOT_W-1];
      drem_r   <= drem_nxt;
      dq_r     <= dq_nxt;
      dlen_r[0]  <= len_e_r;
      dneg_r[0]  <= neg_e_r;
      dzero_r[0] <= zero_e_r;
      for (int j = 1; j < QUO_W; j++) begin
        dlen_r[j]  <= dlen_r[j-1];
        dneg_r[j]  <= dneg_r[j-1];
        dzero_r[j] <= dzero_r[j-1];
      end
      vout_r <= vout_nxt;
    end
  end

  assign vout = vout_r;

endmodule

[tb/billboard_basis_vectors_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Billboard basis vectors testbench
// Drives camera and object words through every align mode and locked axis
// setting, predicts each basis in fixed point and checks every output word.
// ----------------------------------------------------------------------------
module billboard_basis_vectors_test;
  import bbv_pkg::*;

  typedef struct { longint c[3]; } v3_t;
  typedef logic [IN_TDATA_W-1:0]  in_word_t;
  typedef logic [OUT_TDATA_W-1:0] basis_word_t;

  localparam int SETTLE = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  in_word_t in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  basis_word_t out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  cfg_t cfg_data = '0;

  in_word_t    word_q[$];
  basis_word_t basis_q[$];
  cfg_t        cur_mode = MODE_SCREEN;
  cfg_t        cur_axis = AXIS_X;
  int          cycle = 0;
  int          mismatches = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  logic        hold_out = 1'b0;

  billboard_basis_vectors DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic v3_t vec(longint x, longint y, longint z);
    v3_t v;
    v.c[0] = x; v.c[1] = y; v.c[2] = z;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic v3_t unit_vec(v3_t v);
    longint unsigned mag[3];
    longint unsigned m, sum, len, q;
    int s;
    v3_t r;
    m = 0; sum = 0; s = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v.c[i] < 0 ? longint'(-v.c[i]) : longint'(v.c[i]);
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) return vec(longint'(1) << OUT_FRAC_BITS, 0, 0);
    while ((m >> s) >= (64'd1 << 30)) s++;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> s;
      sum = sum + mag[i] * mag[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << OUT_FRAC_BITS) + (len >> 1)) / len;
      r.c[i] = v.c[i] < 0 ? -longint'(q) : longint'(q);
    end
    return r;
  endfunction

  function automatic v3_t cross3(v3_t a, v3_t b);
    return vec(a.c[1] * b.c[2] - a.c[2] * b.c[1],
               a.c[2] * b.c[0] - a.c[0] * b.c[2],
               a.c[0] * b.c[1] - a.c[1] * b.c[0]);
  endfunction

  function automatic comp_t sat16(longint v);
    if (v > 32767) return comp_t'(32767);
    if (v < -32768) return comp_t'(-32768);
    return comp_t'(v);
  endfunction

  function automatic longint fld(in_word_t w, int i);
    return longint'(signed'(w[32*i +: 32]));
  endfunction

  function automatic basis_word_t billboard_basis(in_word_t w, cfg_t mode, cfg_t axis);
    longint one;
    v3_t up_in, look, to_cam, dir, rt, up, fw;
    basis_word_t o;
    one = longint'(1) << OUT_FRAC_BITS;
    up_in  = vec(fld(w, 0), fld(w, 1), fld(w, 2));
    look   = vec(fld(w, 3), fld(w, 4), fld(w, 5));
    to_cam = vec(fld(w, 6) - fld(w, 9), fld(w, 7) - fld(w, 10), fld(w, 8) - fld(w, 11));
    rt = vec(one, 0, 0); up = vec(0, one, 0); fw = vec(0, 0, one);
    if (mode == MODE_SCREEN) begin
      fw = unit_vec(look);
      for (int i = 0; i < 3; i++) fw.c[i] = -fw.c[i];
      up = unit_vec(up_in);
      rt = unit_vec(cross3(up, fw));
    end else if (mode == MODE_CAMERA) begin
      fw = unit_vec(to_cam);
      rt = unit_vec(cross3(unit_vec(up_in), fw));
      up = unit_vec(cross3(fw, rt));
    end else if (mode == MODE_AXIS) begin
      dir = unit_vec(to_cam);
      if (axis == AXIS_X) begin
        up = unit_vec(cross3(dir, rt));
        fw = unit_vec(cross3(rt, up));
      end else if (axis == AXIS_Y) begin
        rt = unit_vec(cross3(up, dir));
        fw = unit_vec(cross3(rt, up));
      end else if (axis == AXIS_Z) begin
        rt = unit_vec(cross3(dir, fw));
        up = unit_vec(cross3(fw, rt));
      end
    end
    for (int i = 0; i < 3; i++) begin
      o[16*i +: 16]       = sat16(rt.c[i]);
      o[16*(3+i) +: 16]   = sat16(up.c[i]);
      o[16*(6+i) +: 16]   = sat16(fw.c[i]);
    end
    return o;
  endfunction

  function automatic logic [31:0] rand_q16();
    int k;
    k = $urandom_range(99);
    if (k < 40) return $urandom;
    if (k < 70) return 32'($signed($urandom_range(2097152)) - 1048576);
    if (k < 80) return 32'h0;
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0001;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    int k;
    for (int i = 0; i < IN_FIELDS; i++) w[32*i +: 32] = rand_q16();
    k = $urandom_range(19);
    if (k == 0) w[32*9 +: 96] = w[32*6 +: 96];        // object at the camera
    else if (k == 1) w[32*3 +: 96] = w[32*0 +: 96];   // up parallel to look
    else if (k == 2) begin                            // to-camera along one axis
      w[32*9 +: 96] = w[32*6 +: 96];
      w[32*(9 + $urandom_range(2)) +: 32] = $urandom;
    end
    return w;
  endfunction

  function automatic in_word_t mk_word(logic [31:0] f[12]);
    in_word_t w;
    for (int i = 0; i < IN_FIELDS; i++) w[32*i +: 32] = f[i];
    return w;
  endfunction

  task automatic queue_directed();
    logic [31:0] mx, mn, u;
    mx = 32'h7fff_ffff; mn = 32'h8000_0000; u = 32'h0001_0000;
    word_q.push_back('0);
    word_q.push_back({IN_FIELDS{mx}});
    word_q.push_back({IN_FIELDS{mn}});
    word_q.push_back(mk_word('{0, u, 0, 0, 0, u, 0, 0, 5*u, 0, 0, 0}));
    word_q.push_back(mk_word('{0, u, 0, 0, u, 0, mx, mx, mx, mn, mn, mn}));
    word_q.push_back(mk_word('{mn, mx, 1, mx, mn, 32'hffff_ffff, mn, mn, mn, mx, mx, mx}));
    word_q.push_back(mk_word('{u, 0, 0, 0, 0, 32'hffff_0000, 3*u, 0, 0, 0, 0, 0}));
    word_q.push_back(mk_word('{0, 0, u, 0, u, 0, 0, 7*u, 0, 0, 0, 0}));
    word_q.push_back(mk_word('{0, u, 0, u, 0, 0, 0, 0, u, 0, 0, 0}));
    word_q.push_back(mk_word('{1, 1, 1, 1, 1, 1, 1, 2, 3, 3, 2, 1}));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, cfg_t val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_ALIGN_MODE) cur_mode = val;
    else cur_axis = val;
  endtask

  always @(posedge clk) cycle <= cycle + 1;

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        basis_q.push_back(billboard_basis(in_tdata, cur_mode, cur_axis));
        n_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (word_q.size() > 0 &&
            ((cycle > 3000 && cycle < 4500) || $urandom_range(99) >= 22)) begin
          in_tdata  <= word_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (basis_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", out_tdata);
        end else begin
          basis_word_t exp_w;
          exp_w = basis_q.pop_front();
          n_checked++;
          for (int i = 0; i < OUT_FIELDS; i++) begin
            if (out_tdata[16*i +: 16] !== exp_w[16*i +: 16]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("word %0d field %0d: expected %0d, got %0d", n_checked, i,
                         $signed(exp_w[16*i +: 16]), $signed(out_tdata[16*i +: 16]));
            end
          end
        end
      end
      out_tready <= !hold_out &&
                    ((cycle > 3000 && cycle < 4500) || $urandom_range(99) >= 22);
    end
  end

  // long output back-pressure to fill the pipeline
  initial begin
    wait (rst_n);
    repeat (60) @(posedge clk);
    hold_out <= 1'b1;
    repeat (400) @(posedge clk);
    hold_out <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    cfg_t modes[8];
    cfg_t axes[8];
    int n_rand;
    modes = '{MODE_SCREEN, MODE_CAMERA, MODE_AXIS, MODE_AXIS, MODE_AXIS,
              cfg_t'(3), MODE_AXIS, MODE_SCREEN};
    axes  = '{AXIS_X, AXIS_X, AXIS_X, AXIS_Y, AXIS_Z, AXIS_X, cfg_t'(3), cfg_t'(3)};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_ALIGN_MODE, modes[p]);
      write_reg(REG_LOCKED_AXIS, axes[p]);
      queue_directed();
      n_rand = (p == 0) ? 500 : 150;
      for (int i = 0; i < n_rand; i++) word_q.push_back(rand_word());
      while (word_q.size() > 0 || in_tvalid || basis_q.size() > 0) @(posedge clk);
      repeat (SETTLE) @(posedge clk);
    end
    $display("%0d words sent, %0d checked over 8 mode/axis settings incl. unused codes",
             n_sent, n_checked);
    if (mismatches == 0 && basis_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatches, basis_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
